// ----- hdl/rptw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptw_pkg
// Shared types, codes and level geometry helpers for the radix page table
// walker.
// ----------------------------------------------------------------------------
package rptw_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned LevelW = 2;
  localparam int unsigned IdxW   = 13;

  // Configuration register indexes
  localparam logic CfgPageSize  = 1'b0;
  localparam logic CfgTableRoot = 1'b1;

  // Entry flag bits
  localparam int unsigned BitPresent = 63;
  localparam int unsigned BitHuge    = 62;
  localparam logic [AddrW-1:0] LinkFlags = 64'hc000_0000_0000_00ff;
  localparam logic [AddrW-1:0] PhysLimit = (64'd1 << 53) - 64'd1;

  // Level shifts
  localparam int unsigned Shift4k  = 12;
  localparam int unsigned Shift64k = 16;
  localparam int unsigned ShiftL1  = 21;
  localparam int unsigned ShiftL2  = 30;
  localparam int unsigned ShiftL3  = 39;

  localparam logic [LevelW-1:0] LevelRoot = 2'd3;
  localparam logic [LevelW-1:0] LevelLast = 2'd0;

  // Input commands
  typedef enum logic [1:0] {
    CMD_SET_CURSOR = 2'd0,
    CMD_START_WALK = 2'd1,
    CMD_READ_RESP  = 2'd2
  } cmd_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ_REQ = 2'd0,
    KIND_XLATE    = 2'd1,
    KIND_FAULT    = 2'd2
  } kind_e;

  // Walk state
  typedef struct packed {
    logic [AddrW-1:0]  cursor;
    logic [LevelW-1:0] level;
    logic              walking;
  } walk_state_t;

  // One result item
  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] mem_address;
    logic             mem_physical;
    logic [AddrW-1:0] range_base;
    logic [AddrW-1:0] phys_base;
    logic             present;
  } result_t;

  // Low-bit mask covering the span of one entry at a level
  function automatic logic [AddrW-1:0] level_mask(input logic geo64k,
                                                  input logic [LevelW-1:0] lvl);
    logic [AddrW-1:0] m;
    case (lvl)
      2'd0: m = geo64k ? ((64'd1 << Shift64k) - 64'd1) : ((64'd1 << Shift4k) - 64'd1);
      2'd1: m = (64'd1 << ShiftL1) - 64'd1;
      2'd2: m = (64'd1 << ShiftL2) - 64'd1;
      2'd3: m = (64'd1 << ShiftL3) - 64'd1;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Table index of the cursor at a level
  function automatic logic [IdxW-1:0] table_index(input logic [AddrW-1:0] va,
                                                  input logic geo64k,
                                                  input logic [LevelW-1:0] lvl);
    logic [IdxW-1:0] idx;
    case (lvl)
      2'd0: idx = geo64k ? {8'd0, va[20:16]} : {4'd0, va[20:12]};
      2'd1: idx = {4'd0, va[29:21]};
      2'd2: idx = {4'd0, va[38:30]};
      2'd3: idx = va[51:39];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// ----- hdl/radix_page_table_walker.sv -----
`timescale 1ns / 1ps
// Result: a result is registered and appears on the master side in the
//   cycle after its request is accepted.
// Throughput: one request per cycle while the result port is not stalled; the
//   64-bit table address add and the cursor advance add lie on the combinational path.
// Reset: cursor, walk level, walk flag, configuration and output valid clear.
// ----------------------------------------------------------------------------
// radix_page_table_walker
// Four-level radix page table walker for 4K or 64K pages with a streaming
// request port, a streaming result port and a register write port.
// ----------------------------------------------------------------------------
module radix_page_table_walker (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration writes
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [63:0]  cfg_wdata_i,
  // Request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // address[63:0], read_data[127:64],
                                       // read_fault[128], zero pad
  input  logic [1:0]   s_axis_tuser,   // command[1:0]
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,   // mem_address[63:0], mem_physical[64],
                                       // range_base[128:65], phys_base[192:129],
                                       // present[193], zero pad
  output logic [1:0]   m_axis_tuser    // kind[1:0]
);

  logic                       geo64k_q;
  logic [63:0]                table_root_q;
  rptw_pkg::walk_state_t      state_q, state_d;
  logic                       out_valid_q, out_valid_d;
  rptw_pkg::result_t          out_q;
  rptw_pkg::result_t          step_res;
  logic                       step_valid;
  logic                       accept;

  // Accept while the result register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo64k_q     <= 1'b0;
      table_root_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rptw_pkg::CfgPageSize:  geo64k_q     <= cfg_wdata_i[0];
        rptw_pkg::CfgTableRoot: table_root_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rptw_step u_step (
    .state_i      (state_q),
    .command_i    (s_axis_tuser),
    .address_i    (s_axis_tdata[63:0]),
    .read_data_i  (s_axis_tdata[127:64]),
    .read_fault_i (s_axis_tdata[128]),
    .geo64k_i     (geo64k_q),
    .table_root_i (table_root_q),
    .state_o      (state_d),
    .res_valid_o  (step_valid),
    .result_o     (step_res)
  );

  // Hold or load the result register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (accept && step_valid) begin
      out_valid_d = 1'b1;
    end
  end

  // Walk state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && step_valid) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'd0, out_q.present, out_q.phys_base, out_q.range_base,
                          out_q.mem_physical, out_q.mem_address};

endmodule

// ----- hdl/rptw_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptw_step
// One walk step: from the current walk state and an incoming request, forms
// the next state and the result item, if any.
// ----------------------------------------------------------------------------
module rptw_step (
  input  rptw_pkg::walk_state_t         state_i,
  input  logic [1:0]                    command_i,
  input  logic [rptw_pkg::AddrW-1:0]    address_i,
  input  logic [rptw_pkg::AddrW-1:0]    read_data_i,
  input  logic                          read_fault_i,
  input  logic                          geo64k_i,
  input  logic [rptw_pkg::AddrW-1:0]    table_root_i,
  output rptw_pkg::walk_state_t         state_o,
  output logic                          res_valid_o,
  output rptw_pkg::result_t             result_o
);

  logic [rptw_pkg::AddrW-1:0]  mask;
  logic [rptw_pkg::AddrW-1:0]  base;
  logic [rptw_pkg::IdxW-1:0]   idx;
  logic [rptw_pkg::LevelW-1:0] idx_level;
  logic [rptw_pkg::LevelW-1:0] down_level;
  logic                        pres;
  logic                        leaf;

  // Geometry of the entry in hand and of the next table
  assign down_level = state_i.level - 2'd1;
  assign mask       = rptw_pkg::level_mask(geo64k_i, state_i.level);
  assign pres       = read_data_i[rptw_pkg::BitPresent];
  assign leaf       = !pres || read_data_i[rptw_pkg::BitHuge] ||
                      (state_i.level == rptw_pkg::LevelLast);

  // Select the table base and level for a read request
  always_comb begin
    if (command_i == rptw_pkg::CMD_START_WALK) begin
      base      = table_root_i;
      idx_level = rptw_pkg::LevelRoot;
    end else begin
      base      = read_data_i & ~rptw_pkg::LinkFlags;
      idx_level = down_level;
    end
  end
  assign idx = rptw_pkg::table_index(state_i.cursor, geo64k_i, idx_level);

  // Decode the request and step the walk
  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    result_o    = '0;
    result_o.kind = rptw_pkg::KIND_READ_REQ;
    case (command_i)
      rptw_pkg::CMD_SET_CURSOR: begin
        state_o.cursor  = address_i;
        state_o.walking = 1'b0;
      end
      rptw_pkg::CMD_START_WALK: begin
        state_o.walking      = 1'b1;
        state_o.level        = rptw_pkg::LevelRoot;
        res_valid_o          = 1'b1;
        result_o.mem_address = base + {48'd0, idx, 3'd0};
        result_o.mem_physical = 1'b0;
      end
      rptw_pkg::CMD_READ_RESP: begin
        if (state_i.walking) begin
          res_valid_o = 1'b1;
          if (read_fault_i) begin
            state_o.walking = 1'b0;
            result_o.kind   = rptw_pkg::KIND_FAULT;
          end else if (leaf) begin
            result_o.kind       = rptw_pkg::KIND_XLATE;
            result_o.range_base = state_i.cursor & ~mask;
            result_o.phys_base  = pres ? (read_data_i & rptw_pkg::PhysLimit & ~mask) : '1;
            result_o.present    = pres;
            state_o.cursor      = (state_i.cursor | mask) + 64'd1;
            state_o.walking     = 1'b0;
          end else begin
            state_o.level         = down_level;
            result_o.mem_address  = base + {48'd0, idx, 3'd0};
            result_o.mem_physical = 1'b1;
          end
        end
      end
      default: begin
        // reserved command: drop
      end
    endcase
  end

endmodule
